FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge
`define STI_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define STI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/sti_pkg.sv
// ----------------------------------------------------------------------------
// sti_pkg
// Shared sizes, command and status codes and control types of the sorted
// id table.
// ----------------------------------------------------------------------------
package sti_pkg;

  // table size and derived widths
  localparam int CAPACITY = 128;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // word field widths
  localparam int CMD_W       = 2;
  localparam int KEY_W       = 16;
  localparam int STATUS_W    = 2;
  localparam int POSITION_W  = 7;
  localparam int ENTRY_CNT_W = 8;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd3;

  // controller states
  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic commit;
  } ctl_t;

endpackage

FILE: design/sti_in_if.sv
// ----------------------------------------------------------------------------
// sti_in_if
// Command channel: one word carries a command and a key.
// ----------------------------------------------------------------------------
interface sti_in_if;
  logic                        valid;
  logic                        ready;
  logic [sti_pkg::CMD_W-1:0]   cmd;
  logic [sti_pkg::KEY_W-1:0]   key;

  modport source (output valid, output cmd, output key, input ready);
  modport sink   (input valid, input cmd, input key, output ready);
endinterface

FILE: design/sti_out_if.sv
// ----------------------------------------------------------------------------
// sti_out_if
// Result channel: one word per command with status, hit flag, slot and count.
// ----------------------------------------------------------------------------
interface sti_out_if;
  logic                              valid;
  logic                              ready;
  logic [sti_pkg::STATUS_W-1:0]      status;
  logic                              found;
  logic [sti_pkg::POSITION_W-1:0]    position;
  logic [sti_pkg::ENTRY_CNT_W-1:0]   entry_count;

  modport source (output valid, output status, output found, output position,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input found, input position,
                  input entry_count, output ready);
endinterface

FILE: design/sti_ctrl.sv
// ----------------------------------------------------------------------------
// sti_ctrl
// Controller: accepts one command word, then commits it once the result
// register is free to take the new word.
// ----------------------------------------------------------------------------
module sti_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output sti_pkg::ctl_t ctl
);

  sti_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            room;

  // result register can take a word this cycle
  assign room = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sti_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = sti_pkg::ST_EXEC;
      end
      sti_pkg::ST_EXEC: begin
        if (room) state_nxt = sti_pkg::ST_IDLE;
      end
      default: state_nxt = sti_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready    = 1'b0;
    ctl.capture = 1'b0;
    ctl.commit  = 1'b0;
    case (state_r)
      sti_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        ctl.capture = in_valid;
      end
      sti_pkg::ST_EXEC: begin
        ctl.commit = room;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // result valid flag
  always_comb begin
    if (ctl.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sti_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: design/sti_dpath.sv
// ----------------------------------------------------------------------------
// sti_dpath
// Datapath: a row of key slots, each comparing against the key on capture
// and shifting up or down by one on commit, plus the count and result word.
// ----------------------------------------------------------------------------
module sti_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sti_pkg::ctl_t                       ctl,
  input  logic [sti_pkg::CMD_W-1:0]           in_cmd,
  input  logic [sti_pkg::KEY_W-1:0]           in_key,
  output logic [sti_pkg::STATUS_W-1:0]        out_status,
  output logic                                out_found,
  output logic [sti_pkg::POSITION_W-1:0]      out_position,
  output logic [sti_pkg::ENTRY_CNT_W-1:0]     out_entry_count,
  output logic [sti_pkg::CNT_W-1:0]           count
);

  localparam int CAP = sti_pkg::CAPACITY;

  logic [sti_pkg::KEY_W-1:0]      slots_r [CAP];
  logic [sti_pkg::KEY_W-1:0]      slots_nxt [CAP];
  logic [sti_pkg::CNT_W-1:0]      count_r, count_nxt;
  logic [CAP-1:0]                 lt_r, lt_nxt;
  logic [CAP-1:0]                 eq_r, eq_nxt;
  logic [CAP-1:0]                 edge_hot;
  logic [sti_pkg::KEY_W-1:0]      key_r;
  logic [sti_pkg::CMD_W-1:0]      cmd_r;

  logic [sti_pkg::STATUS_W-1:0]   status_r, status_nxt;
  logic                           found_r;
  logic [sti_pkg::POSITION_W-1:0] position_r, position_nxt;
  logic [sti_pkg::ENTRY_CNT_W-1:0] entry_count_r;

  logic                           present;
  logic                           full;
  logic                           ins_ok;
  logic                           del_ok;
  logic [sti_pkg::IDX_W-1:0]      slot_idx;

  // per-slot compare against the incoming key, masked to held slots
  for (genvar i = 0; i < CAP; i++) begin : g_cmp
    logic held;
    assign held      = sti_pkg::CNT_W'(i) < count_r;
    assign lt_nxt[i] = held && (slots_r[i] < in_key);
    assign eq_nxt[i] = held && (slots_r[i] == in_key);
  end

  // first slot not below the key: edge of the less-than run
  for (genvar i = 0; i < CAP; i++) begin : g_edge
    if (i == 0) begin : g_first
      assign edge_hot[i] = !lt_r[i];
    end else begin : g_rest
      assign edge_hot[i] = !lt_r[i] && lt_r[i-1];
    end
  end

  // one-hot edge to slot index
  always_comb begin
    slot_idx = '0;
    for (int i = 0; i < CAP; i++) begin
      if (edge_hot[i]) slot_idx = slot_idx | sti_pkg::IDX_W'(i);
    end
  end

  // command decision
  assign present = |eq_r;
  assign full    = count_r >= sti_pkg::CNT_W'(CAP);
  assign ins_ok  = (cmd_r == sti_pkg::CMD_INSERT) && !full && !present;
  assign del_ok  = (cmd_r == sti_pkg::CMD_DELETE) && present;

  always_comb begin
    case (cmd_r)
      sti_pkg::CMD_INSERT: begin
        if (full) begin
          status_nxt = sti_pkg::STAT_FULL;
        end else if (present) begin
          status_nxt = sti_pkg::STAT_DUPLICATE;
        end else begin
          status_nxt = sti_pkg::STAT_OK;
        end
      end
      default: begin
        status_nxt = present ? sti_pkg::STAT_OK : sti_pkg::STAT_NOT_FOUND;
      end
    endcase
  end

  assign position_nxt = (present || ins_ok) ? sti_pkg::POSITION_W'(slot_idx)
                                            : '0;

  always_comb begin
    count_nxt = count_r;
    if (ins_ok) begin
      count_nxt = count_r + sti_pkg::CNT_W'(1);
    end else if (del_ok) begin
      count_nxt = count_r - sti_pkg::CNT_W'(1);
    end
  end

  // per-slot shift: up past the insert point, down past the removed slot
  for (genvar i = 0; i < CAP; i++) begin : g_shift
    logic [sti_pkg::KEY_W-1:0] below;
    logic [sti_pkg::KEY_W-1:0] above;
    if (i == 0) begin : g_lo
      assign below = slots_r[i];
    end else begin : g_lo
      assign below = slots_r[i-1];
    end
    if (i == CAP - 1) begin : g_hi
      assign above = slots_r[i];
    end else begin : g_hi
      assign above = slots_r[i+1];
    end
    always_comb begin
      slots_nxt[i] = slots_r[i];
      if (!lt_r[i]) begin
        if (ins_ok) begin
          slots_nxt[i] = edge_hot[i] ? key_r : below;
        end else if (del_ok) begin
          slots_nxt[i] = above;
        end
      end
    end
  end

  // capture registers
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      key_r <= in_key;
      cmd_r <= in_cmd;
      lt_r  <= lt_nxt;
      eq_r  <= eq_nxt;
    end
  end

  // table and result word update
  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      for (int i = 0; i < CAP; i++) begin
        slots_r[i] <= slots_nxt[i];
      end
      status_r      <= status_nxt;
      found_r       <= present;
      position_r    <= position_nxt;
      entry_count_r <= sti_pkg::ENTRY_CNT_W'(count_nxt);
    end
  end

  // key count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctl.commit) begin
      count_r <= count_nxt;
    end
  end

  assign out_status      = status_r;
  assign out_found       = found_r;
  assign out_position    = position_r;
  assign out_entry_count = entry_count_r;
  assign count           = count_r;

endmodule

FILE: design/sorted_id_table.sv
// ----------------------------------------------------------------------------
// sorted_id_table
// Table of unique 16-bit keys in ascending order with insert, lookup and
// delete. In the cycle a command word is accepted the key is compared
// against every held slot at once. Once the output register is free, the
// commit follows: an insert or delete shifts the table by one slot in a
// single step, the count moves and the result word is loaded into the
// output register. The next command word is taken only after that commit,
// so the block works on one word at a time; a stalled result holds the
// commit until the output register frees. After reset the table is empty
// and ready at once: slots above the count are never looked at, so no
// clearing pass is made. Insert into a full table reports full even for a
// key already held; command code 3 acts as a lookup.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_id_table (
  input  logic       clk,
  input  logic       rst_n,
  sti_in_if.sink     in_chan,
  sti_out_if.source  out_chan
);

  sti_pkg::ctl_t             ctl;
  logic [sti_pkg::CNT_W-1:0] count;

  // sequencing
  sti_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .ctl       (ctl)
  );

  // slot row, count and result word
  sti_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .in_cmd          (in_chan.cmd),
    .in_key          (in_chan.key),
    .out_status      (out_chan.status),
    .out_found       (out_chan.found),
    .out_position    (out_chan.position),
    .out_entry_count (out_chan.entry_count),
    .count           (count)
  );

  // checks
  `STI_ASSERT(a_count_bound, count <= sti_pkg::CNT_W'(sti_pkg::CAPACITY), "count above capacity")
  `STI_ASSERT_NEXT(a_one_word, in_chan.valid && in_chan.ready, !in_chan.ready, "second word taken while busy")
  `STI_ASSERT_NEXT(a_count_hold, !ctl.commit, $stable(count), "count moved without a commit")

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sorted_id_table. A local copy of the sorted key
// table predicts the result word of every command word at the moment it is
// accepted. A checker compares each returned word with the oldest prediction.
// Directed words cover the key extremes, every command and the duplicate,
// missing-key and unused-code cases. A fill pass runs the table to full and
// back to empty. A stall pass holds the result side off for a long stretch.
// Random phases then mix inserts, lookups and deletes under changing idle
// patterns on both sides.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // code 3 is not used by the block and acts as a lookup
  localparam logic [sti_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int POOL_SIZE   = 48;
  localparam int LONG_STALL  = 300;

  typedef struct packed {
    logic [sti_pkg::STATUS_W-1:0]    status;
    logic                            found;
    logic [sti_pkg::POSITION_W-1:0]  position;
    logic [sti_pkg::ENTRY_CNT_W-1:0] entry_count;
  } table_result_t;

  logic clk = 1'b0;
  logic rst_n;

  sti_in_if  in_chan ();
  sti_out_if out_chan ();

  sorted_id_table dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // predicted table contents
  logic [sti_pkg::KEY_W-1:0] table_keys [sti_pkg::CAPACITY];
  int                        table_count = 0;

  table_result_t             pending_results [$];
  logic [sti_pkg::KEY_W-1:0] key_pool [POOL_SIZE];

  int err_count     = 0;
  int word_count    = 0;
  int cycle_count   = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_request = 0;
  int hold_left     = 0;
  int cmd_tally [4] = '{default: 0};
  int stat_tally [4] = '{default: 0};

  always #4 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // apply one command to the local table and return the result word
  function automatic table_result_t apply_table_op(logic [sti_pkg::CMD_W-1:0] op,
                                                   logic [sti_pkg::KEY_W-1:0] k);
    table_result_t r;
    int slot;
    bit present;
    slot = table_count;
    for (int i = 0; i < table_count; i++) begin
      if (table_keys[i] >= k) begin
        slot = i;
        break;
      end
    end
    present = (slot < table_count) && (table_keys[slot] == k);
    r.found = present;
    r.position = present ? slot[sti_pkg::POSITION_W-1:0] : '0;
    case (op)
      sti_pkg::CMD_INSERT: begin
        if (table_count >= sti_pkg::CAPACITY) begin
          r.status = sti_pkg::STAT_FULL;
        end else if (present) begin
          r.status = sti_pkg::STAT_DUPLICATE;
        end else begin
          for (int i = table_count; i > slot; i--) table_keys[i] = table_keys[i-1];
          table_keys[slot] = k;
          table_count++;
          r.position = slot[sti_pkg::POSITION_W-1:0];
          r.status = sti_pkg::STAT_OK;
        end
      end
      sti_pkg::CMD_DELETE: begin
        if (present) begin
          for (int i = slot; i + 1 < table_count; i++) table_keys[i] = table_keys[i+1];
          table_count--;
          r.status = sti_pkg::STAT_OK;
        end else begin
          r.status = sti_pkg::STAT_NOT_FOUND;
        end
      end
      default: begin
        r.status = present ? sti_pkg::STAT_OK : sti_pkg::STAT_NOT_FOUND;
      end
    endcase
    r.entry_count = table_count[sti_pkg::ENTRY_CNT_W-1:0];
    return r;
  endfunction

  // send one command word, predict its result at acceptance
  task automatic send_word(logic [sti_pkg::CMD_W-1:0] op, logic [sti_pkg::KEY_W-1:0] k);
    if ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.cmd   <= op;
    in_chan.key   <= k;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    pending_results.push_back(apply_table_op(op, k));
    cmd_tally[op]++;
    word_count++;
  endtask

  // drop valid and wait for every outstanding result
  task automatic wait_drain();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // result side ready, with random idling and requested long holds
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (stall_request > 0) begin
        hold_left = stall_request;
        stall_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic void check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val,
               act_val);
    end
  endfunction

  // compare each result word with the oldest prediction
  always @(posedge clk) begin
    table_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      stat_tally[out_chan.status]++;
      if (pending_results.size() == 0) begin
        err_count++;
        $display("%0t: result word with none expected, status %0d position %0d",
                 $time, out_chan.status, out_chan.position);
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, out_chan.status);
        check_field("found", want.found, out_chan.found);
        check_field("position", want.position, out_chan.position);
        check_field("entry_count", want.entry_count, out_chan.entry_count);
      end
    end
  end

  // key extremes, every command and the special cases
  task automatic test_directed();
    send_word(sti_pkg::CMD_LOOKUP, 16'h0000);
    send_word(sti_pkg::CMD_DELETE, 16'h1234);
    send_word(sti_pkg::CMD_INSERT, 16'h8000);
    send_word(sti_pkg::CMD_INSERT, 16'h0000);
    send_word(sti_pkg::CMD_INSERT, 16'hFFFF);
    send_word(sti_pkg::CMD_INSERT, 16'h7FFF);
    send_word(sti_pkg::CMD_INSERT, 16'h5555);
    send_word(sti_pkg::CMD_INSERT, 16'hAAAA);
    send_word(sti_pkg::CMD_INSERT, 16'h8000);
    send_word(sti_pkg::CMD_LOOKUP, 16'hFFFF);
    send_word(sti_pkg::CMD_LOOKUP, 16'h0000);
    send_word(sti_pkg::CMD_LOOKUP, 16'h1235);
    send_word(CMD_UNUSED, 16'h5555);
    send_word(CMD_UNUSED, 16'h4444);
    send_word(sti_pkg::CMD_DELETE, 16'h7FFF);
    send_word(sti_pkg::CMD_DELETE, 16'h7FFF);
    send_word(sti_pkg::CMD_DELETE, 16'h0000);
    send_word(sti_pkg::CMD_DELETE, 16'hFFFF);
    send_word(sti_pkg::CMD_LOOKUP, 16'hAAAA);
    send_word(sti_pkg::CMD_INSERT, 16'h0001);
    wait_drain();
  endtask

  // fill to capacity in scrambled order, poke the full table, empty it
  task automatic test_fill();
    while (table_count > 0) send_word(sti_pkg::CMD_DELETE, table_keys[0]);
    for (int i = 0; i < sti_pkg::CAPACITY; i++)
      send_word(sti_pkg::CMD_INSERT, 16'(((i * 37) % sti_pkg::CAPACITY) * 509 + 7));
    send_word(sti_pkg::CMD_INSERT, 16'h0003);
    send_word(sti_pkg::CMD_INSERT, 16'd7);
    send_word(sti_pkg::CMD_LOOKUP, 16'((sti_pkg::CAPACITY - 1) * 509 + 7));
    send_word(sti_pkg::CMD_DELETE, 16'((sti_pkg::CAPACITY - 1) * 509 + 7));
    send_word(sti_pkg::CMD_INSERT, 16'hFFFF);
    send_word(sti_pkg::CMD_INSERT, 16'hFFFE);
    while (table_count > 0)
      send_word(sti_pkg::CMD_DELETE, table_keys[$urandom_range(table_count - 1)]);
    wait_drain();
  endtask

  // long result hold while words keep coming, then a full pause
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_request = LONG_STALL;
    for (int i = 0; i < 30; i++) begin
      send_word((i % 3 == 0) ? sti_pkg::CMD_LOOKUP : sti_pkg::CMD_INSERT, 16'($urandom));
    end
    wait_drain();
  endtask

  // random mix, keys mostly held or from a small pool for frequent hits
  task automatic test_random(int n, int ins_pct, int s_pct, int r_pct);
    logic [sti_pkg::CMD_W-1:0] op;
    logic [sti_pkg::KEY_W-1:0] k;
    int pick;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < ins_pct) begin
        op = sti_pkg::CMD_INSERT;
      end else begin
        pick = $urandom_range(99);
        op = (pick < 35) ? sti_pkg::CMD_LOOKUP :
             (pick < 90) ? sti_pkg::CMD_DELETE : CMD_UNUSED;
      end
      pick = $urandom_range(99);
      if (pick < 45 && table_count > 0) begin
        k = table_keys[$urandom_range(table_count - 1)];
      end else if (pick < 85) begin
        k = key_pool[$urandom_range(POOL_SIZE - 1)];
      end else begin
        k = 16'($urandom);
      end
      send_word(op, k);
    end
    wait_drain();
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.cmd   <= sti_pkg::CMD_INSERT;
    in_chan.key   <= '0;
    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = 16'($urandom);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 12;
    recv_idle_pct = 48;
    test_directed();
    test_fill();
    test_backpressure();
    test_random(180, 45, 12, 48);
    test_random(180, 70, 48, 12);
    test_random(180, 35, 0, 0);

    repeat (20) @(posedge clk);
    $display("Covered %0d command words: %0d insert, %0d lookup, %0d delete, %0d unused",
             word_count, cmd_tally[sti_pkg::CMD_INSERT], cmd_tally[sti_pkg::CMD_LOOKUP],
             cmd_tally[sti_pkg::CMD_DELETE], cmd_tally[CMD_UNUSED]);
    $display("Results seen: %0d ok, %0d duplicate, %0d full, %0d not found",
             stat_tally[sti_pkg::STAT_OK], stat_tally[sti_pkg::STAT_DUPLICATE],
             stat_tally[sti_pkg::STAT_FULL], stat_tally[sti_pkg::STAT_NOT_FOUND]);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
